FILE: hw/rtl/queued_mutex_lock_unit_core_assert.svh
// Assertion macros for the queued mutex lock unit.
// Used by the sequencer; needs a clock and an active-low reset in scope at the call.
`ifndef QUEUED_MUTEX_LOCK_UNIT_CORE_ASSERT_SVH
`define QUEUED_MUTEX_LOCK_UNIT_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define QMLU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies a result in the next.
`define QMLU_ASSERT_NEXT(lbl, clk, rst_n, cond, res, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`endif

FILE: hw/rtl/qmlu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the queued mutex lock unit.
// No dependencies; imported by every module of the unit.
package qmlu_pkg;

    // Default sizes
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;

    // Port field widths
    localparam int KIND_W    = 2;
    localparam int REQ_ID_W  = 8;
    localparam int STATUS_W  = 3;
    localparam int OUT_ID_W  = 8;
    localparam int WAITING_W = 5;

    typedef enum logic [KIND_W-1:0] {
        K_LOCK   = 2'd0,
        K_TRY    = 2'd1,
        K_UNLOCK = 2'd2,
        K_CANCEL = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACQUIRED  = 3'd0,
        ST_BUSY      = 3'd1,
        ST_QUEUED    = 3'd2,
        ST_FULL      = 3'd3,
        ST_RELEASED  = 3'd4,
        ST_HANDOFF   = 3'd5,
        ST_CANCELLED = 3'd6,
        ST_NOTWAIT   = 3'd7
    } t_status;

    typedef struct packed {
        t_status                status;
        logic [OUT_ID_W-1:0]    woken_id;
        logic                   held;
        logic [OUT_ID_W-1:0]    holder_id;
        logic [WAITING_W-1:0]   waiting;
    } t_result;

endpackage

FILE: hw/rtl/qmlu_mem.sv
`timescale 1ns / 1ps
// Wait queue storage: one write port, one read port with registered data.
// Depends on qmlu_pkg.
module qmlu_mem
    import qmlu_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    localparam int PTR_W      = $clog2(QUEUE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [PTR_W-1:0]   i_waddr,
    input  logic [ID_BITS-1:0] i_wdata,
    input  logic [PTR_W-1:0]   i_raddr,
    output logic [ID_BITS-1:0] o_rdata
);

    logic [ID_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [ID_BITS-1:0] r_rdata;

    // Write one entry, read one entry each cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/qmlu_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the queued mutex lock unit: lock state, ring pointers, and the
// shared pointer stepper and ID comparator. Depends on qmlu_pkg and the assert header.
`include "queued_mutex_lock_unit_core_assert.svh"
module qmlu_ctrl
    import qmlu_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    localparam int PTR_W      = $clog2(QUEUE_DEPTH),
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request side
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  t_kind              i_kind,
    input  logic [ID_BITS-1:0] i_who,
    // result side
    output logic               o_res_valid,
    input  logic               i_res_take,
    output t_result            o_res,
    // queue memory
    output logic               o_mem_we,
    output logic [PTR_W-1:0]   o_mem_waddr,
    output logic [ID_BITS-1:0] o_mem_wdata,
    output logic [PTR_W-1:0]   o_mem_raddr,
    input  logic [ID_BITS-1:0] i_mem_rdata
);

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_HAND  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [ID_BITS-1:0] r_who, n_who;
    logic               r_held, n_held;
    logic [ID_BITS-1:0] r_holder, n_holder;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_idx, n_idx;
    t_result            r_res, n_res;

    logic [PTR_W-1:0]   step_in;
    logic [PTR_W-1:0]   step_out;
    logic               id_match;
    logic               scan_last;
    logic               fin;
    t_status            fin_status;
    logic [ID_BITS-1:0] fin_woken;

    // Shared ring pointer stepper: tail on enqueue, head on hand off, scan pointer otherwise
    always_comb begin
        case (r_state)
            S_EXEC:  step_in = r_tail;
            S_HAND:  step_in = r_head;
            default: step_in = r_rd_ptr;
        endcase
        step_out = (step_in == LAST_PTR) ? '0 : step_in + PTR_W'(1);
    end

    // Shared comparator and end-of-queue detect for the scan
    assign id_match  = (i_mem_rdata == r_who);
    assign scan_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // Sequence one request
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_who       = r_who;
        n_held      = r_held;
        n_holder    = r_holder;
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_idx       = r_idx;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wr_ptr;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_rd_ptr;
        fin         = 1'b0;
        fin_status  = ST_RELEASED;
        fin_woken   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind  = i_kind;
                    n_who   = i_who;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_kind)
                    K_LOCK, K_TRY: begin
                        fin = 1'b1;
                        if (!r_held) begin
                            n_held     = 1'b1;
                            n_holder   = r_who;
                            fin_status = ST_ACQUIRED;
                        end else if (r_kind == K_TRY) begin
                            fin_status = ST_BUSY;
                        end else if (r_count < FULL_CNT) begin
                            // Append at the tail
                            o_mem_we    = 1'b1;
                            o_mem_waddr = r_tail;
                            o_mem_wdata = r_who;
                            n_tail      = step_out;
                            n_count     = r_count + CNT_W'(1);
                            fin_status  = ST_QUEUED;
                        end else begin
                            fin_status = ST_FULL;
                        end
                    end
                    K_UNLOCK: begin
                        if (r_held && (r_count != '0)) begin
                            o_mem_raddr = r_head;
                            n_state     = S_HAND;
                        end else begin
                            n_held     = 1'b0;
                            n_holder   = '0;
                            fin_status = ST_RELEASED;
                            fin        = 1'b1;
                        end
                    end
                    K_CANCEL: begin
                        if (r_count == '0) begin
                            fin_status = ST_NOTWAIT;
                            fin        = 1'b1;
                        end else begin
                            o_mem_raddr = r_head;
                            n_rd_ptr    = r_head;
                            n_idx       = '0;
                            n_state     = S_SCAN;
                        end
                    end
                    default: begin
                        fin_status = ST_NOTWAIT;
                        fin        = 1'b1;
                    end
                endcase
            end
            S_HAND: begin
                // Pop the head waiter and make it the owner
                n_holder   = i_mem_rdata;
                n_head     = step_out;
                n_count    = r_count - CNT_W'(1);
                fin_woken  = i_mem_rdata;
                fin_status = ST_HANDOFF;
                fin        = 1'b1;
            end
            S_SCAN: begin
                if (id_match && scan_last) begin
                    n_tail     = r_rd_ptr;
                    n_count    = r_count - CNT_W'(1);
                    fin_status = ST_CANCELLED;
                    fin        = 1'b1;
                end else if (id_match) begin
                    // Close the gap: move later entries one place toward the head
                    n_wr_ptr    = r_rd_ptr;
                    o_mem_raddr = step_out;
                    n_rd_ptr    = step_out;
                    n_idx       = r_idx + PTR_W'(1);
                    n_state     = S_SHIFT;
                end else if (scan_last) begin
                    fin_status = ST_NOTWAIT;
                    fin        = 1'b1;
                end else begin
                    o_mem_raddr = step_out;
                    n_rd_ptr    = step_out;
                    n_idx       = r_idx + PTR_W'(1);
                end
            end
            S_SHIFT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_wr_ptr;
                o_mem_wdata = i_mem_rdata;
                n_wr_ptr    = r_rd_ptr;
                if (scan_last) begin
                    n_tail     = r_rd_ptr;
                    n_count    = r_count - CNT_W'(1);
                    fin_status = ST_CANCELLED;
                    fin        = 1'b1;
                end else begin
                    o_mem_raddr = step_out;
                    n_rd_ptr    = step_out;
                    n_idx       = r_idx + PTR_W'(1);
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Capture the result from the updated state
        if (fin) begin
            n_state           = S_DONE;
            n_res.status      = fin_status;
            n_res.woken_id    = OUT_ID_W'(fin_woken);
            n_res.held        = n_held;
            n_res.holder_id   = n_held ? OUT_ID_W'(n_holder) : '0;
            n_res.waiting     = WAITING_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= 1'b0;
            r_holder <= '0;
            r_count  <= '0;
            r_head   <= '0;
            r_tail   <= '0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_holder <= n_holder;
            r_count  <= n_count;
            r_head   <= n_head;
            r_tail   <= n_tail;
        end
    end

    // Request payload and scan registers
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_who    <= n_who;
        r_rd_ptr <= n_rd_ptr;
        r_wr_ptr <= n_wr_ptr;
        r_idx    <= n_idx;
        r_res    <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    `QMLU_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "wait count above depth")
    `QMLU_ASSERT(a_free_empty, i_clk, i_rst_n, !r_held |-> ((r_count == '0) && (r_holder == '0)), "free mutex with waiters or owner")
    `QMLU_ASSERT_NEXT(a_hand_pop, i_clk, i_rst_n, r_state == S_HAND, r_held && (r_count == $past(r_count) - CNT_W'(1)), "hand off did not pop one waiter")
    `QMLU_ASSERT(a_write_phase, i_clk, i_rst_n, o_mem_we |-> ((r_state == S_EXEC) || (r_state == S_SHIFT)), "queue write outside enqueue or shift")

endmodule

FILE: hw/rtl/queued_mutex_lock_unit_core.sv
`timescale 1ns / 1ps
// Top level of the queued mutex lock unit: stream ports, result register.
// Depends on qmlu_pkg, qmlu_mem and qmlu_ctrl.
//
//  channel | dir | tuser               | tdata (low bit first)
//  s_axis  | in  | kind[1:0]           | requester[7:0]
//  m_axis  | out | status[2:0]         | woken_id[7:0], held, holder_id[7:0],
//          |     |                     | waiting[4:0], 2 zero bits
//
// Lock, try-lock and release go from accept through the execute state to the result;
// hand off passes through the hand-off state as well. Cancel also scans or moves the
// waiters one at a time through the single read port of the queue memory.
// A request is taken only while the sequencer is idle; a result waiting in the
// output register does not block the next request, but a second finished result
// holds until it drains. Reset is synchronous, active low, and empties the queue.
module queued_mutex_lock_unit_core
    import qmlu_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // requester[7:0]
    input  logic [KIND_W-1:0] i_s_axis_tuser,   // kind[1:0]
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [23:0]       o_m_axis_tdata,   // woken_id, held, holder_id, waiting, pad
    output logic [2:0]        o_m_axis_tuser    // status[2:0]
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    logic [ID_BITS-1:0] mem_wdata;
    logic [PTR_W-1:0]   mem_raddr;
    logic [ID_BITS-1:0] mem_rdata;
    logic               res_valid;
    logic               res_take;
    t_result            res;
    logic [ID_BITS-1:0] who;
    logic               r_out_valid;
    t_result            r_out;

    // Keep only the identifier bits in use
    assign who = ID_BITS'(i_s_axis_tdata);

    qmlu_mem #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    qmlu_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_s_axis_tvalid),
        .o_req_ready(o_s_axis_tready),
        .i_kind     (t_kind'(i_s_axis_tuser)),
        .i_who      (who),
        .o_res_valid(res_valid),
        .i_res_take (res_take),
        .o_res      (res),
        .o_mem_we   (mem_we),
        .o_mem_waddr(mem_waddr),
        .o_mem_wdata(mem_wdata),
        .o_mem_raddr(mem_raddr),
        .i_mem_rdata(mem_rdata)
    );

    // Load the output register when it is empty or being drained
    assign res_take = res_valid && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {2'b00, r_out.waiting, r_out.holder_id, r_out.held,
                              r_out.woken_id};

endmodule
